// ----- hdl/chte_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants of the chained hash table engine
// Word formats, codes, sizes and small helper functions used by all modules but the generic RAM.
// ----------------------------------------------------------------------------
package chte_pkg;

  // table geometry
  localparam int BINS     = 256;
  localparam int CAPACITY = 1024;
  localparam int BIN_AW   = $clog2(BINS);
  localparam int NODE_AW  = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int BC_W     = 9;
  localparam int KEY_W    = 32;

  // modulo unit: four quotient bits per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = KEY_W / DIV_BITS;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // mixed hash: key bits 25:24 are folded in
  localparam int MIX_LSB = 24;

  // configuration register indexes
  localparam logic [1:0] REG_HASH_MODE  = 2'd0;
  localparam logic [1:0] REG_BIN_COUNT  = 2'd1;
  localparam logic [1:0] REG_ALLOW_DUPS = 2'd2;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    HM_PLAIN = 2'd0,
    HM_MIXED = 2'd1,
    HM_PAIR  = 2'd2,
    HM_NONE  = 2'd3
  } hash_mode_e;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] key_a;
    logic signed [31:0] key_b;
    logic [31:0]        value;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] found_value;
    logic [10:0] entry_total;
  } out_word_t;

  typedef struct packed {
    hash_mode_e      hash_mode;
    logic [BC_W-1:0] bin_count;
    logic            allow_duplicates;
  } cfg_t;

  // classified request passed from front to back
  typedef struct packed {
    in_word_t          word;
    logic              hash_ok;
    logic [BIN_AW-1:0] idx;
  } q_item_t;

  // bin count in use: zero acts as one, above BINS acts as BINS
  function automatic logic [BC_W-1:0] eff_bins(input logic [BC_W-1:0] bc);
    logic [BC_W-1:0] r;
    r = bc;
    if (bc == '0) r = BC_W'(1);
    else if (bc > BC_W'(BINS)) r = BC_W'(BINS);
    return r;
  endfunction

  // one restoring step of the remainder
  function automatic logic [BIN_AW-1:0] div_step(input logic [BIN_AW-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [BC_W-1:0] bc);
    logic [BC_W-1:0] r2;
    r2 = {rem, bit_in};
    if (r2 >= bc) r2 = r2 - bc;
    return r2[BIN_AW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/chained_hash_table_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_engine: hash table with chained bins
// Insert, remove, find and clear on up to 1024 entries in up to 256 bins.
// ----------------------------------------------------------------------------
// One word in gives one word out. The front skips the remainder unit when
// the bin count is a power of two, and also for clear and the unused hash
// mode; otherwise the unit retires four hash bits per cycle. The back goes
// straight to the result for clear or the unused hash mode, skips the head
// read for an empty bin, and otherwise reads the bin head and walks the
// chain node by node. A new entry adds an allocation step, and in a used bin
// also a link step. The chain walk is set by the single read port of the node
// memories. A two-word queue lets the front work on the next request while
// the back walks a chain, so the steady rate is the slower of the two. Clear
// takes effect as it leaves the queue; no clearing pass follows reset.
module chained_hash_table_engine import chte_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [8:0] cfg_data_i
);

  cfg_t    cfg_q;
  logic    push, full, pop, q_valid;
  q_item_t push_item, pop_item;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{hash_mode: HM_PLAIN, bin_count: BC_W'(BINS), allow_duplicates: 1'b0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HASH_MODE:  cfg_q.hash_mode <= hash_mode_e'(cfg_data_i[1:0]);
        REG_BIN_COUNT:  cfg_q.bin_count <= cfg_data_i;
        REG_ALLOW_DUPS: cfg_q.allow_duplicates <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  chte_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i, .in_stall_o, .in_word_i,
    .push_o(push), .push_item_o(push_item), .full_i(full));

  chte_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_item_i(push_item), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .pop_item_o(pop_item));

  chte_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_item_i(pop_item), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_word_o);

endmodule
`default_nettype wire

// ----- hdl/chte_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chte_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module chte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/chte_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chte_front: request intake and bin index calculation
// Hashes the key and reduces it to a bin index, by mask or by a
// four-bit-per-cycle remainder unit, then hands the request to the queue.
// ----------------------------------------------------------------------------
module chte_front import chte_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_word_i,
  output logic          push_o,
  output q_item_t       push_item_o,
  input  wire logic     full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  front_state_e      state_q, state_d;
  in_word_t          word_q, word_d;
  logic              ok_q, ok_d;
  logic [BIN_AW-1:0] idx_q, idx_d;
  logic [KEY_W-1:0]  h_q, h_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;

  logic [BC_W-1:0]   bc;
  logic [BC_W-1:0]   bc_m1;
  logic              pow2;
  logic [KEY_W-1:0]  hash;
  logic [KEY_W-1:0]  ka;
  logic [BIN_AW-1:0] rem_step;

  assign bc    = eff_bins(cfg_i.bin_count);
  assign bc_m1 = bc - BC_W'(1);
  assign pow2  = (bc & bc_m1) == '0;
  assign ka    = $unsigned(in_word_i.key_a);

  // hash of the incoming key
  always_comb begin
    unique case (cfg_i.hash_mode)
      HM_MIXED: hash = (ka << 2) + KEY_W'(ka[MIX_LSB+1:MIX_LSB]);
      HM_PAIR:  hash = ka + $unsigned(in_word_i.key_b);
      default:  hash = ka;
    endcase
  end

  // four restoring steps on the top nibble
  always_comb begin
    rem_step = idx_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_step = div_step(rem_step, h_q[KEY_W-1-i], bc);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    word_d  = word_q;
    ok_d    = ok_q;
    idx_d   = idx_q;
    h_d     = h_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          word_d = in_word_i;
          ok_d   = (cfg_i.hash_mode != HM_NONE);
          h_d    = hash;
          cnt_d  = '0;
          if (in_word_i.action == ACT_CLEAR || cfg_i.hash_mode == HM_NONE) begin
            idx_d   = '0;
            state_d = F_PUSH;
          end else if (pow2) begin
            idx_d   = hash[BIN_AW-1:0] & bc_m1[BIN_AW-1:0];
            state_d = F_PUSH;
          end else begin
            idx_d   = '0;
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        idx_d = rem_step;
        h_d   = h_q << DIV_BITS;
        cnt_d = cnt_q + DIV_CW'(1);
        if (cnt_q == DIV_CW'(DIV_STEPS - 1)) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != F_IDLE);
  assign push_item_o = '{word: word_q, hash_ok: ok_q, idx: idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= F_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    ok_q   <= ok_d;
    idx_q  <= idx_d;
    h_q    <= h_d;
    cnt_q  <= cnt_d;
  end

endmodule
`default_nettype wire

// ----- hdl/chte_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chte_queue: two-entry queue between front and back
// Lets the front classify the next request while the back walks a chain.
// ----------------------------------------------------------------------------
module chte_queue import chte_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire q_item_t push_item_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output q_item_t      pop_item_o
);

  q_item_t    ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_item_o = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wptr_q] <= push_item_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/chte_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chte_back: chain walker and table updater
// Reads the bin head, walks the chain one node per cycle, then links,
// unlinks or reports, and places the result in the output register.
// ----------------------------------------------------------------------------
module chte_back import chte_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire logic    q_valid_i,
  input  wire q_item_t q_item_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_word_t    out_word_o
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_HEAD,
    B_NODE,
    B_ACT,
    B_ALLOC,
    B_LINK,
    B_DONE
  } back_state_e;

  back_state_e        state_q, state_d;
  q_item_t            it_q, it_d;
  logic [NODE_AW-1:0] head_q, head_d, cur_q, cur_d, hprev_q, hprev_d;
  logic [NODE_AW-1:0] nx_q, nx_d, pv_q, pv_d, new_q, new_d;
  logic               first_q, first_d, hit_q, hit_d;
  logic [31:0]        data_q, data_d, found_q, found_d;
  status_e            st_q, st_d;
  logic [CNT_W-1:0]   entry_q, entry_d, stack_q, stack_d, hwm_q, hwm_d;
  logic [BINS-1:0]    used_q, used_d;
  logic               out_vld_q, out_vld_d;
  out_word_t          out_q, out_d;

  // memory ports
  logic                 head_we;
  logic [BIN_AW-1:0]    head_waddr, head_raddr;
  logic [NODE_AW-1:0]   head_wdata, head_rdata;
  logic                 key_we;
  logic [NODE_AW-1:0]   node_raddr;
  logic [31:0]          kf_wdata, ks_wdata, dt_wdata;
  logic [31:0]          kf_rdata, ks_rdata, dt_rdata;
  logic                 nxt_we, prv_we, fs_we;
  logic [NODE_AW-1:0]   nxt_waddr, nxt_wdata, nxt_rdata;
  logic [NODE_AW-1:0]   prv_waddr, prv_wdata, prv_rdata;
  logic [NODE_AW-1:0]   fs_waddr, fs_wdata, fs_raddr, fs_rdata;

  logic               match;
  logic [NODE_AW-1:0] nn;
  logic [CNT_W-1:0]   stack_m1;

  assign match = (kf_rdata == $unsigned(it_q.word.key_a)) &&
                 (cfg_i.hash_mode != HM_PAIR || ks_rdata == $unsigned(it_q.word.key_b));
  assign stack_m1 = stack_q - CNT_W'(1);
  assign nn = (stack_q != '0) ? fs_rdata : hwm_q[NODE_AW-1:0];

  chte_ram #(.WIDTH(NODE_AW), .DEPTH(BINS)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata));
  chte_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_kf (
    .clk_i, .we_i(key_we), .waddr_i(new_d), .wdata_i(kf_wdata),
    .raddr_i(node_raddr), .rdata_o(kf_rdata));
  chte_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ks (
    .clk_i, .we_i(key_we), .waddr_i(new_d), .wdata_i(ks_wdata),
    .raddr_i(node_raddr), .rdata_o(ks_rdata));
  chte_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_data (
    .clk_i, .we_i(key_we), .waddr_i(new_d), .wdata_i(dt_wdata),
    .raddr_i(node_raddr), .rdata_o(dt_rdata));
  chte_ram #(.WIDTH(NODE_AW), .DEPTH(CAPACITY)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(node_raddr), .rdata_o(nxt_rdata));
  chte_ram #(.WIDTH(NODE_AW), .DEPTH(CAPACITY)) u_prev (
    .clk_i, .we_i(prv_we), .waddr_i(prv_waddr), .wdata_i(prv_wdata),
    .raddr_i(node_raddr), .rdata_o(prv_rdata));
  chte_ram #(.WIDTH(NODE_AW), .DEPTH(CAPACITY)) u_free (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata));

  assign kf_wdata = $unsigned(it_q.word.key_a);
  assign ks_wdata = (cfg_i.hash_mode == HM_PAIR) ? $unsigned(it_q.word.key_b) : '0;
  assign dt_wdata = it_q.word.value;

  // sequencer
  always_comb begin
    state_d   = state_q;
    it_d      = it_q;
    head_d    = head_q;
    cur_d     = cur_q;
    hprev_d   = hprev_q;
    nx_d      = nx_q;
    pv_d      = pv_q;
    new_d     = new_q;
    first_d   = first_q;
    hit_d     = hit_q;
    data_d    = data_q;
    found_d   = found_q;
    st_d      = st_q;
    entry_d   = entry_q;
    stack_d   = stack_q;
    hwm_d     = hwm_q;
    used_d    = used_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    pop_o      = 1'b0;
    head_we    = 1'b0;
    head_waddr = it_q.idx;
    head_wdata = new_q;
    head_raddr = q_item_i.idx;
    key_we     = 1'b0;
    node_raddr = cur_q;
    nxt_we     = 1'b0;
    nxt_waddr  = new_q;
    nxt_wdata  = new_q;
    prv_we     = 1'b0;
    prv_waddr  = new_q;
    prv_wdata  = new_q;
    fs_we      = 1'b0;
    fs_waddr   = stack_q[NODE_AW-1:0];
    fs_wdata   = cur_q;
    fs_raddr   = stack_m1[NODE_AW-1:0];
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          it_d    = q_item_i;
          hit_d   = 1'b0;
          found_d = '0;
          st_d    = ST_NOT_FOUND;
          if (q_item_i.word.action == ACT_CLEAR) begin
            used_d  = '0;
            entry_d = '0;
            stack_d = '0;
            hwm_d   = '0;
            st_d    = ST_OK;
            state_d = B_DONE;
          end else if (!q_item_i.hash_ok) begin
            state_d = B_DONE;
          end else if (!used_q[q_item_i.idx]) begin
            state_d = B_ACT;
          end else begin
            state_d = B_HEAD;
          end
        end
      end
      B_HEAD: begin
        head_d     = head_rdata;
        cur_d      = head_rdata;
        node_raddr = head_rdata;
        first_d    = 1'b1;
        state_d    = B_NODE;
      end
      B_NODE: begin
        // one chain node per cycle
        first_d = 1'b0;
        if (first_q) hprev_d = prv_rdata;
        if (match) begin
          hit_d   = 1'b1;
          data_d  = dt_rdata;
          nx_d    = nxt_rdata;
          pv_d    = prv_rdata;
          state_d = B_ACT;
        end else if (nxt_rdata == head_q) begin
          state_d = B_ACT;
        end else begin
          cur_d      = nxt_rdata;
          node_raddr = nxt_rdata;
        end
      end
      B_ACT: begin
        state_d = B_DONE;
        priority case (it_q.word.action)
          ACT_INSERT: begin
            if (!cfg_i.allow_duplicates && hit_q) st_d = ST_DUPLICATE;
            else if (entry_q == CNT_W'(CAPACITY)) st_d = ST_FULL;
            else state_d = B_ALLOC;
          end
          default: begin
            if (hit_q) begin
              st_d    = ST_OK;
              found_d = data_q;
              if (it_q.word.action == ACT_REMOVE) begin
                // unlink the node and return it to the pool
                if (nx_q == cur_q) begin
                  used_d[it_q.idx] = 1'b0;
                end else begin
                  prv_we    = 1'b1;
                  prv_waddr = nx_q;
                  prv_wdata = pv_q;
                  nxt_we    = 1'b1;
                  nxt_waddr = pv_q;
                  nxt_wdata = nx_q;
                  if (head_q == cur_q) begin
                    head_we    = 1'b1;
                    head_wdata = nx_q;
                  end
                end
                fs_we   = 1'b1;
                stack_d = stack_q + CNT_W'(1);
                entry_d = entry_q - CNT_W'(1);
              end
            end
          end
        endcase
      end
      B_ALLOC: begin
        // take a node and fill it
        new_d  = nn;
        key_we = 1'b1;
        if (stack_q != '0) stack_d = stack_m1;
        else               hwm_d   = hwm_q + CNT_W'(1);
        entry_d   = entry_q + CNT_W'(1);
        st_d      = ST_OK;
        nxt_we    = 1'b1;
        nxt_waddr = nn;
        prv_we    = 1'b1;
        prv_waddr = nn;
        if (used_q[it_q.idx]) begin
          nxt_wdata = head_q;
          prv_wdata = hprev_q;
          state_d   = B_LINK;
        end else begin
          nxt_wdata        = nn;
          prv_wdata        = nn;
          head_we          = 1'b1;
          head_wdata       = nn;
          used_d[it_q.idx] = 1'b1;
          state_d          = B_DONE;
        end
      end
      B_LINK: begin
        // append after the old tail
        nxt_we    = 1'b1;
        nxt_waddr = hprev_q;
        nxt_wdata = new_q;
        prv_we    = 1'b1;
        prv_waddr = head_q;
        prv_wdata = new_q;
        state_d   = B_DONE;
      end
      B_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_d     = '{status: st_q, found_value: found_q, entry_total: entry_q};
          state_d   = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      entry_q   <= '0;
      stack_q   <= '0;
      hwm_q     <= '0;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      entry_q   <= entry_d;
      stack_q   <= stack_d;
      hwm_q     <= hwm_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q    <= it_d;
    head_q  <= head_d;
    cur_q   <= cur_d;
    hprev_q <= hprev_d;
    nx_q    <= nx_d;
    pv_q    <= pv_d;
    new_q   <= new_d;
    first_q <= first_d;
    hit_q   <= hit_d;
    data_q  <= data_d;
    found_q <= found_d;
    st_q    <= st_d;
    out_q   <= out_d;
  end

endmodule
`default_nettype wire

// ----- hdl/chte_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chte_checker: port-level checks of the hash table engine
// Watches the request and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module chte_checker import chte_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire in_word_t   in_word_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire out_word_t  out_word_o
);

  // a stalled request word stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("request word dropped or changed while stalled");

  // a stalled result word stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  // entry count never exceeds the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.entry_total <= 11'(CAPACITY))
    else $error("entry total above capacity");

  // only a successful request reports a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_OK |-> out_word_o.found_value == '0)
    else $error("value reported on failed request");

  // a full status comes only with the entry total at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_FULL |->
      out_word_o.entry_total == 11'(CAPACITY))
    else $error("full status with free nodes");

endmodule

bind chained_hash_table_engine chte_checker u_chte_checker (.*);
`default_nettype wire

// ----- tb/chte_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_scoreboard: table predictor and result scoreboard
// Watches the request, result and register channels of the chained hash table
// engine, keeps its own copy of the table, and compares every result word.
// ----------------------------------------------------------------------------
module chte_scoreboard import chte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_word_t   in_word_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_word_t  out_word_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  // shadow registers
  hash_mode_e  mode_q;
  logic [8:0]  bins_q;
  logic        dups_q;

  // shadow table
  logic [9:0]  head_m   [BINS];
  logic        used_m   [BINS];
  logic [31:0] key1_m   [CAPACITY];
  logic [31:0] key2_m   [CAPACITY];
  logic [31:0] data_m   [CAPACITY];
  logic [9:0]  next_m   [CAPACITY];
  logic [9:0]  prev_m   [CAPACITY];
  logic [9:0]  free_m   [CAPACITY];
  int          free_cnt;
  int          entries;

  out_word_t   expected_q[$];
  int          fails;
  int          checked;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();
  assign checked_o    = checked;

  function automatic void empty_table();
    for (int i = 0; i < BINS; i++) begin
      head_m[i] = '0;
      used_m[i] = 1'b0;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      key1_m[i] = '0;
      key2_m[i] = '0;
      data_m[i] = '0;
      next_m[i] = '0;
      prev_m[i] = '0;
      free_m[i] = 10'(i);
    end
    free_cnt = CAPACITY;
    entries  = 0;
  endfunction

  // bin index from the key word; returns 0 for the unused hash mode
  function automatic bit bin_of(input logic [31:0] ka, input logic [31:0] kb,
                                output int unsigned idx);
    int unsigned bc;
    logic [31:0] h;
    bc = bins_q;
    idx = 0;
    if (bc == 0) bc = 1;
    if (bc > BINS) bc = BINS;
    case (mode_q)
      HM_PLAIN: h = ka;
      HM_MIXED: h = (ka << 2) + {30'd0, ka[25:24]};
      HM_PAIR:  h = ka + kb;
      default:  return 0;
    endcase
    if ((bc & (bc - 1)) == 0) idx = h & (bc - 1);
    else idx = h % bc;
    return 1;
  endfunction

  // first match from the chain head
  function automatic bit chain_lookup(input int unsigned idx, input logic [31:0] ka,
                                      input logic [31:0] kb, output int unsigned hit);
    int unsigned n;
    hit = 0;
    if (!used_m[idx]) return 0;
    n = head_m[idx];
    for (int s = 0; s < CAPACITY; s++) begin
      if (key1_m[n] == ka && (mode_q != HM_PAIR || key2_m[n] == kb)) begin
        hit = n;
        return 1;
      end
      n = next_m[n];
      if (n == head_m[idx]) break;
    end
    return 0;
  endfunction

  function automatic out_word_t table_request(input in_word_t w);
    out_word_t   r;
    int unsigned idx, n, h, t, nx, pv;
    bit          hit;
    r.status      = ST_NOT_FOUND;
    r.found_value = '0;
    if (w.action == ACT_CLEAR) begin
      empty_table();
      r.status = ST_OK;
    end else if (bin_of(w.key_a, w.key_b, idx)) begin
      hit = chain_lookup(idx, w.key_a, w.key_b, n);
      if (w.action == ACT_INSERT) begin
        if (!dups_q && hit) r.status = ST_DUPLICATE;
        else if (free_cnt == 0) r.status = ST_FULL;
        else begin
          free_cnt--;
          n = free_m[free_cnt];
          key1_m[n] = w.key_a;
          key2_m[n] = (mode_q == HM_PAIR) ? w.key_b : '0;
          data_m[n] = w.value;
          if (used_m[idx]) begin
            h = head_m[idx];
            t = prev_m[h];
            next_m[n] = 10'(h);
            prev_m[n] = 10'(t);
            next_m[t] = 10'(n);
            prev_m[h] = 10'(n);
          end else begin
            head_m[idx] = 10'(n);
            next_m[n]   = 10'(n);
            prev_m[n]   = 10'(n);
            used_m[idx] = 1'b1;
          end
          entries++;
          r.status = ST_OK;
        end
      end else if (hit) begin
        r.found_value = data_m[n];
        r.status      = ST_OK;
        if (w.action == ACT_REMOVE) begin
          nx = next_m[n];
          pv = prev_m[n];
          if (nx == n) used_m[idx] = 1'b0;
          else begin
            prev_m[nx] = 10'(pv);
            next_m[pv] = 10'(nx);
            if (head_m[idx] == n) head_m[idx] = 10'(nx);
          end
          if (free_cnt < CAPACITY) begin
            free_m[free_cnt] = 10'(n);
            free_cnt++;
          end
          if (entries > 0) entries--;
        end
      end
    end
    r.entry_total = 11'(entries);
    return r;
  endfunction

  initial begin
    fails   = 0;
    checked = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      mode_q = HM_PLAIN;
      bins_q = 9'd256;
      dups_q = 1'b0;
      empty_table();
      expected_q.delete();
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_HASH_MODE:  mode_q = hash_mode_e'(cfg_data_i[1:0]);
          REG_BIN_COUNT:  bins_q = cfg_data_i;
          REG_ALLOW_DUPS: dups_q = cfg_data_i[0];
          default: ;
        endcase
      end
      // result words
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("ERROR: unexpected result word %p", out_word_i);
        end else begin
          e = expected_q.pop_front();
          if (e.status != out_word_i.status || e.found_value != out_word_i.found_value ||
              e.entry_total != out_word_i.entry_total) begin
            fails++;
            if (fails <= 10)
              $display("ERROR: result %0d: status %0d/%0d value %h/%h total %0d/%0d (exp/act)",
                       checked, e.status, out_word_i.status, e.found_value,
                       out_word_i.found_value, e.entry_total, out_word_i.entry_total);
          end
        end
      end
      // request words
      if (in_valid_i && !in_stall_i) expected_q.push_back(table_request(in_word_i));
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: chained hash table engine testbench
// Drives directed and random table requests through several register
// settings with random idling on both sides; the checker scores results.
// ----------------------------------------------------------------------------
module tb_top;
  import chte_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  int fails, pending, checked;
  int words_sent = 0;
  int idle_cycles = 0;
  int holds_asked = 0;
  bit quiet = 1'b0;

  logic [31:0] key_pool_a [32];
  logic [31:0] key_pool_b [32];

  chained_hash_table_engine dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  chte_scoreboard u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_word_i(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fails), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // result side: random stall bursts, plus long holds on request
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      if (holds_done < holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: watchdog expired, %0d results outstanding", pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one request word; returns at the accepting edge
  task automatic send_word(input action_e act, input logic [31:0] ka,
                           input logic [31:0] kb, input logic [31:0] val);
    bit st;
    in_word.action <= act;
    in_word.key_a  <= ka;
    in_word.key_b  <= kb;
    in_word.value  <= val;
    in_valid       <= 1'b1;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    words_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // drain, then write one register
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    bit rdy;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_table(input hash_mode_e hm, input logic [8:0] bc, input bit dups);
    write_reg(REG_HASH_MODE, 9'(hm));
    write_reg(REG_BIN_COUNT, bc);
    write_reg(REG_ALLOW_DUPS, 9'(dups));
  endtask

  // mostly keys from a small pool so requests hit existing entries
  task automatic random_requests(input int count);
    int r, p;
    logic [31:0] ka, kb;
    action_e act;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) act = ACT_INSERT;
      else if (r < 70) act = ACT_FIND;
      else if (r < 97) act = ACT_REMOVE;
      else act = ACT_CLEAR;
      p = $urandom_range(0, 31);
      if ($urandom_range(0, 4) != 0) begin
        ka = key_pool_a[p];
        kb = key_pool_b[p];
      end else begin
        ka = $urandom;
        kb = $urandom;
      end
      send_word(act, ka, kb, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) begin
      key_pool_a[i] = $urandom;
      key_pool_b[i] = $urandom;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, chaining in one bin, duplicates, misses, clear
    send_word(ACT_INSERT, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_word(ACT_INSERT, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
    send_word(ACT_INSERT, 32'h0000_0000, 32'hffff_ffff, 32'h1234_5678);
    send_word(ACT_INSERT, 32'hffff_ffff, 32'h0000_0000, 32'h8765_4321);
    send_word(ACT_INSERT, 32'h0000_0100, 32'h0, 32'haaaa_5555);
    send_word(ACT_INSERT, 32'h0000_0200, 32'h0, 32'h5555_aaaa);
    send_word(ACT_INSERT, 32'h0000_0100, 32'h0, 32'hdead_beef);
    send_word(ACT_FIND,   32'h7fff_ffff, 32'h0, 32'h0);
    send_word(ACT_FIND,   32'h0000_0200, 32'h0, 32'h0);
    send_word(ACT_FIND,   32'h0000_0300, 32'h0, 32'h0);
    send_word(ACT_REMOVE, 32'h0000_0100, 32'h0, 32'h0);
    send_word(ACT_REMOVE, 32'h0000_0100, 32'h0, 32'h0);
    send_word(ACT_REMOVE, 32'h0000_0000, 32'h0, 32'h0);
    send_word(ACT_FIND,   32'h0000_0200, 32'h0, 32'h0);
    send_word(ACT_INSERT, 32'h0000_0000, 32'h0, 32'h0000_0001);
    send_word(ACT_FIND,   32'hffff_ffff, 32'h0, 32'h0);
    send_word(ACT_CLEAR,  32'h0, 32'h0, 32'h0);
    send_word(ACT_FIND,   32'h7fff_ffff, 32'h0, 32'h0);
    // unused hash mode: lookups miss, clear still works
    set_table(HM_NONE, 9'd256, 1'b0);
    send_word(ACT_INSERT, 32'h1, 32'h1, 32'h1);
    send_word(ACT_FIND,   32'h1, 32'h1, 32'h0);
    send_word(ACT_REMOVE, 32'h1, 32'h1, 32'h0);
    send_word(ACT_CLEAR,  32'h0, 32'h0, 32'h0);

    // fill the whole pool with duplicates allowed, then overflow it
    set_table(HM_PLAIN, 9'd256, 1'b1);
    for (int i = 0; i < 1030; i++) begin
      if (i == 500) holds_asked++;
      send_word(ACT_INSERT, 32'($urandom_range(0, 2047)), $urandom, $urandom);
    end
    random_requests(20);
    send_word(ACT_CLEAR, 32'h0, 32'h0, 32'h0);

    // sender pause until every result is back
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    set_table(HM_MIXED, 9'd7, 1'b1);
    random_requests(60);
    set_table(HM_PAIR, 9'd1, 1'b0);
    random_requests(60);
    set_table(HM_PLAIN, 9'd0, 1'b0);
    random_requests(50);
    set_table(HM_MIXED, 9'd511, 1'b0);
    random_requests(60);
    set_table(HM_PAIR, 9'd100, 1'b1);
    random_requests(60);
    set_table(HM_PLAIN, 9'd256, 1'b0);
    quiet = 1'b1;
    random_requests(60);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d request words and %0d result words over eight table settings,",
             words_sent, checked);
    $display("including a full node pool, a long result hold and every hash mode.");
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fails, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/chte_pkg.sv
hdl/chte_ram.sv
hdl/chte_front.sv
hdl/chte_queue.sv
hdl/chte_back.sv
hdl/chained_hash_table_engine.sv
hdl/chte_checker.sv
tb/chte_checker.sv
tb/tb_top.sv
